// ===== rtl/core/radial_scaled_deadzone_unit_defines.svh =====
// Assertion macros shared by the radial dead zone RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef RADIAL_SCALED_DEADZONE_UNIT_DEFINES_SVH
`define RADIAL_SCALED_DEADZONE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define RSDZ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle.
`define RSDZ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RSDZ_ASSERT(label, clk, rst, prop, msg)
`define RSDZ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/rsdz_pkg.sv =====
// Types and fixed widths for the radial dead zone pipeline.
// No dependencies.
package rsdz_pkg;

  localparam int MAG_W      = 24;  // magnitude, 8 fraction bits
  localparam int SQRT_STEPS = 24;  // one root bit per stage
  localparam int DIV_STEPS  = 24;  // one quotient bit per stage
  localparam int F_STEPS    = 17;  // scale factor bits, 16 fraction bits

  // Direction data carried alongside every stage
  typedef struct packed {
    logic [14:0] ax;
    logic [14:0] ay;
    logic        xneg;
    logic        yneg;
  } side_t;

  typedef struct packed {
    logic        v;
    side_t       side;
    logic [25:0] rem;
    logic [23:0] root;
    logic [47:0] rad;
  } sqrt_t;

  typedef struct packed {
    logic        v;
    side_t       side;
    logic [15:0] rem;
    logic [23:0] num_lo;
    logic [23:0] q;
    logic [14:0] d;
    logic [23:0] mag;
  } div_t;

  typedef struct packed {
    logic        v;
    side_t       side;
    logic        centred;
    logic [49:0] r;
    logic [47:0] den;
    logic [16:0] f;
  } frac_t;

endpackage

// ===== rtl/core/radial_scaled_deadzone_unit.sv =====
// Radial scaled dead zone for a thumbstick: one sample in, one result out.
// Depends on rsdz_pkg and radial_scaled_deadzone_unit_defines.svh.
//
// Takes one sample per clock unless the output stalls, and returns one result
// per sample, in order. The pipeline has 71 register stages, most of them in
// the bit-serial parts: a 24-stage square root, a 24-stage divider for the
// edge length and a 17-stage divider for the radial factor, one bit per
// register stage. The whole pipeline holds while a finished result waits at
// the output, so in_ready is low only while out_valid is high and out_ready
// low. dz_radius is written through dz_radius_we/dz_radius_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce. It resets to 2000.
`include "radial_scaled_deadzone_unit_defines.svh"

module radial_scaled_deadzone_unit
  import rsdz_pkg::*;
#(
  parameter int FULL_SCALE = 32767
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        dz_radius_we,
  input  logic [14:0] dz_radius_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [14:0] up_in,
  input  logic [14:0] left_in,
  input  logic [14:0] down_in,
  input  logic [14:0] right_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] up_out,
  output logic [14:0] left_out,
  output logic [14:0] down_out,
  output logic [14:0] right_out,
  output logic        active
);

  localparam logic [14:0] FS     = 15'(FULL_SCALE);
  localparam logic [23:0] MX_CAP = 24'(FULL_SCALE * 320);

  logic        adv;
  logic [14:0] dz_radius;
  logic [22:0] dz8;

  logic        a_v;
  side_t       a_side;
  sqrt_t       sq [SQRT_STEPS+1];
  div_t        dv [DIV_STEPS+1];
  logic        c_v;
  side_t       c_side;
  logic [23:0] c_mx;
  logic [23:0] c_mag;
  frac_t       fd [F_STEPS+1];

  // Whole pipeline moves when the output register is free
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign dz8      = {dz_radius, 8'b0};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dz_radius <= 15'd2000;
    end else if (dz_radius_we) begin
      dz_radius <= dz_radius_wdata;
    end
  end

  // Stage a: saturate inputs, form component magnitudes and signs
  logic [14:0] up_s, left_s, down_s, right_s;
  assign up_s    = (up_in    > FS) ? FS : up_in;
  assign left_s  = (left_in  > FS) ? FS : left_in;
  assign down_s  = (down_in  > FS) ? FS : down_in;
  assign right_s = (right_in > FS) ? FS : right_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= in_valid;
    end
    if (adv) begin
      a_side.xneg <= left_s > right_s;
      a_side.yneg <= up_s > down_s;
      a_side.ax   <= (left_s > right_s) ? left_s - right_s : right_s - left_s;
      a_side.ay   <= (up_s > down_s) ? up_s - down_s : down_s - up_s;
    end
  end

  // Stage b: squared length, shifted for 8 fraction bits of root
  logic [31:0] len_sq;
  assign len_sq = {17'b0, a_side.ax} * {17'b0, a_side.ax}
                + {17'b0, a_side.ay} * {17'b0, a_side.ay};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].v <= 1'b0;
    end else if (adv) begin
      sq[0].v <= a_v;
    end
    if (adv) begin
      sq[0].side <= a_side;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].rad  <= {len_sq, 16'b0};
    end
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [25:0] rem_sh;
    logic [25:0] trial;
    logic        ge;
    assign rem_sh = {sq[k].rem[23:0], sq[k].rad[47:46]};
    assign trial  = {sq[k].root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k+1].v <= 1'b0;
      end else if (adv) begin
        sq[k+1].v <= sq[k].v;
      end
      if (adv) begin
        sq[k+1].side <= sq[k].side;
        sq[k+1].rem  <= ge ? rem_sh - trial : rem_sh;
        sq[k+1].root <= {sq[k].root[22:0], ge};
        sq[k+1].rad  <= {sq[k].rad[45:0], 2'b00};
      end
    end
  end

  // Edge length numerator full scale times magnitude, over the larger component
  logic [23:0] mag_r;
  logic [14:0] big;
  logic [38:0] edge_num;
  assign mag_r    = sq[SQRT_STEPS].root;
  assign big      = (sq[SQRT_STEPS].side.ax > sq[SQRT_STEPS].side.ay)
                  ? sq[SQRT_STEPS].side.ax : sq[SQRT_STEPS].side.ay;
  assign edge_num = {24'b0, FS} * {15'b0, mag_r};

  // Quotient is below 2^24, so the top bits start as the partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].v <= 1'b0;
    end else if (adv) begin
      dv[0].v <= sq[SQRT_STEPS].v;
    end
    if (adv) begin
      dv[0].side   <= sq[SQRT_STEPS].side;
      dv[0].rem    <= {1'b0, edge_num[38:24]};
      dv[0].num_lo <= edge_num[23:0];
      dv[0].q      <= '0;
      dv[0].d      <= big;
      dv[0].mag    <= mag_r;
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [15:0] rem_sh;
    logic        ge;
    assign rem_sh = {dv[k].rem[14:0], dv[k].num_lo[23]};
    assign ge     = rem_sh >= {1'b0, dv[k].d};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].v <= 1'b0;
      end else if (adv) begin
        dv[k+1].v <= dv[k].v;
      end
      if (adv) begin
        dv[k+1].side   <= dv[k].side;
        dv[k+1].rem    <= ge ? rem_sh - {1'b0, dv[k].d} : rem_sh;
        dv[k+1].num_lo <= {dv[k].num_lo[22:0], 1'b0};
        dv[k+1].q      <= {dv[k].q[22:0], ge};
        dv[k+1].d      <= dv[k].d;
        dv[k+1].mag    <= dv[k].mag;
      end
    end
  end

  // Stage c: cap edge length at 1.25 full scale, raise to at least magnitude
  logic [23:0] mx_cap;
  assign mx_cap = (dv[DIV_STEPS].q > MX_CAP) ? MX_CAP : dv[DIV_STEPS].q;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= dv[DIV_STEPS].v;
    end
    if (adv) begin
      c_side <= dv[DIV_STEPS].side;
      c_mag  <= dv[DIV_STEPS].mag;
      c_mx   <= (mx_cap < dv[DIV_STEPS].mag) ? dv[DIV_STEPS].mag : mx_cap;
    end
  end

  // Radial factor operands; inside the dead zone they are don't-care
  logic [23:0] mag_less_dz;
  logic [23:0] mx_less_dz;
  logic [47:0] f_num;
  logic [47:0] f_den;
  assign mag_less_dz = c_mag - {1'b0, dz8};
  assign mx_less_dz  = c_mx - {1'b0, dz8};
  assign f_num       = {24'b0, c_mx} * {24'b0, mag_less_dz};
  assign f_den       = {24'b0, c_mag} * {24'b0, mx_less_dz};

  // A zero divisor arises only on the dead-zone edge or inside it; divide by one to keep f zero on the edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fd[0].v <= 1'b0;
    end else if (adv) begin
      fd[0].v <= c_v;
    end
    if (adv) begin
      fd[0].side    <= c_side;
      fd[0].centred <= (c_mag == '0) || (c_mag < {1'b0, dz8});
      fd[0].r       <= {2'b00, f_num};
      fd[0].den     <= (f_den == '0) ? 48'd1 : f_den;
      fd[0].f       <= '0;
    end
  end

  // Factor divider, one bit per stage; ratio is at most one
  for (genvar k = 0; k < F_STEPS; k++) begin : g_frac
    logic        ge;
    logic [49:0] r_sub;
    assign ge    = fd[k].r >= {2'b00, fd[k].den};
    assign r_sub = ge ? fd[k].r - {2'b00, fd[k].den} : fd[k].r;

    always_ff @(posedge clk) begin
      if (rst) begin
        fd[k+1].v <= 1'b0;
      end else if (adv) begin
        fd[k+1].v <= fd[k].v;
      end
      if (adv) begin
        fd[k+1].side    <= fd[k].side;
        fd[k+1].centred <= fd[k].centred;
        fd[k+1].r       <= {r_sub[48:0], 1'b0};
        fd[k+1].den     <= fd[k].den;
        fd[k+1].f       <= {fd[k].f[15:0], ge};
      end
    end
  end

  // Output stage: scale components, split back into directions
  frac_t       fl;
  logic [31:0] sx;
  logic [31:0] sy;
  logic [14:0] ox;
  logic [14:0] oy;
  assign fl = fd[F_STEPS];
  assign sx = {17'b0, fl.side.ax} * {15'b0, fl.f};
  assign sy = {17'b0, fl.side.ay} * {15'b0, fl.f};
  assign ox = fl.centred ? '0 : sx[30:16];
  assign oy = fl.centred ? '0 : sy[30:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fl.v;
    end
    if (adv) begin
      active    <= !fl.centred;
      up_out    <= fl.side.yneg ? oy : '0;
      down_out  <= fl.side.yneg ? '0 : oy;
      left_out  <= fl.side.xneg ? ox : '0;
      right_out <= fl.side.xneg ? '0 : ox;
    end
  end

  // Checks on pipeline and result consistency
  logic out_all_zero;
  assign out_all_zero = (up_out == '0) && (down_out == '0)
                     && (left_out == '0) && (right_out == '0);

  `RSDZ_ASSERT_NEXT(a_take_chk, clk, rst, in_valid && in_ready, a_v, "sample lost at entry")
  `RSDZ_ASSERT(f_range_chk, clk, rst, !fl.v || fl.centred || fl.f <= 17'h10000, "factor above one")
  `RSDZ_ASSERT(centre_zero_chk, clk, rst, !out_valid || active || out_all_zero, "centred not zero")
  `RSDZ_ASSERT(opposed_chk, clk, rst, !out_valid || up_out == '0 || down_out == '0, "up and down set")

endmodule

// ===== verif/rsdz_scoreboard.sv =====
// Checker for the radial scaled dead zone unit: watches both channels and the
// dead-zone write port, predicts each result and compares it on transfer.
// Depends on nothing but the port widths of radial_scaled_deadzone_unit.
`timescale 1ns / 100ps

module rsdz_scoreboard #(
  parameter int FULL_SCALE = 32767
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        dz_radius_we,
  input  logic [14:0] dz_radius_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [14:0] up_in,
  input  logic [14:0] left_in,
  input  logic [14:0] down_in,
  input  logic [14:0] right_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [14:0] up_out,
  input  logic [14:0] left_out,
  input  logic [14:0] down_out,
  input  logic [14:0] right_out,
  input  logic        active,
  output int          pending,
  output int          fail_count
);

  typedef struct packed {
    logic [14:0] up;
    logic [14:0] left;
    logic [14:0] down;
    logic [14:0] right;
    logic        active;
  } stick_out_t;

  logic [14:0] dz_reg;
  stick_out_t  stick_q[$];

  // Integer square root, floor
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [14:0] clip_in(input logic [14:0] v);
    return (v > FULL_SCALE) ? 15'(FULL_SCALE) : v;
  endfunction

  // Rescale one sample against the current dead zone
  function automatic stick_out_t rescale_stick(input logic [14:0] u_i, input logic [14:0] l_i,
                                               input logic [14:0] d_i, input logic [14:0] r_i,
                                               input logic [14:0] dz);
    stick_out_t   res;
    logic [14:0]  u, l, d, r;
    logic         xneg, yneg;
    logic [127:0] ax, ay, dz8, mag8, big, mx8, f16, sx, sy, lim, num, den, rm, larger, c16;
    u = clip_in(u_i);
    l = clip_in(l_i);
    d = clip_in(d_i);
    r = clip_in(r_i);
    res = '0;
    xneg = l > r;
    yneg = u > d;
    ax = xneg ? 128'(l - r) : 128'(r - l);
    ay = yneg ? 128'(u - d) : 128'(d - u);
    dz8 = 128'(dz) << 8;
    mag8 = 128'(int_sqrt(64'((ax * ax + ay * ay) << 16)));
    if (mag8 == 0 || mag8 < dz8) return res;
    res.active = 1'b1;
    big = (ax > ay) ? ax : ay;
    mx8 = (128'(FULL_SCALE) * mag8) / big;
    if (mx8 > 128'(FULL_SCALE) * 320) mx8 = 128'(FULL_SCALE) * 320;
    if (mx8 < mag8) mx8 = mag8;
    f16 = 0;
    if (mag8 != dz8) begin
      num = mx8 * (mag8 - dz8);
      den = mag8 * (mx8 - dz8);
      rm = num;
      for (int i = 0; i < 17; i++) begin
        f16 = f16 << 1;
        if (rm >= den) begin
          rm = rm - den;
          f16 = f16 | 1;
        end
        rm = rm << 1;
      end
    end
    sx = ax * f16;
    sy = ay * f16;
    lim = 128'(FULL_SCALE) << 16;
    if (sx > lim || sy > lim) begin
      larger = (sx > sy) ? sx : sy;
      c16 = (128'(FULL_SCALE) << 32) / larger;
      sx = (c16 * sx) >> 32;
      sy = (c16 * sy) >> 32;
    end else begin
      sx = sx >> 16;
      sy = sy >> 16;
    end
    if (yneg) res.up = sy[14:0];
    else res.down = sy[14:0];
    if (xneg) res.left = sx[14:0];
    else res.right = sx[14:0];
    return res;
  endfunction

  assign pending = stick_q.size();

  // Track the register, queue predictions on input transfer, compare on output transfer
  always @(posedge clk) begin
    stick_out_t want;
    if (rst) begin
      dz_reg <= 15'd2000;
      stick_q.delete();
      fail_count <= 0;
    end else begin
      if (dz_radius_we) dz_reg <= dz_radius_wdata;
      if (in_valid && in_ready)
        stick_q.push_back(rescale_stick(up_in, left_in, down_in, right_in, dz_reg));
      if (out_valid && out_ready) begin
        if (stick_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = stick_q.pop_front();
          if (want.up !== up_out || want.left !== left_out || want.down !== down_out ||
              want.right !== right_out || want.active !== active) begin
            fail_count <= fail_count + 1;
            if (want.up !== up_out) $error("up_out expected %0d actual %0d", want.up, up_out);
            if (want.left !== left_out)
              $error("left_out expected %0d actual %0d", want.left, left_out);
            if (want.down !== down_out)
              $error("down_out expected %0d actual %0d", want.down, down_out);
            if (want.right !== right_out)
              $error("right_out expected %0d actual %0d", want.right, right_out);
            if (want.active !== active)
              $error("active expected %0d actual %0d", want.active, active);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_radial_scaled_deadzone_unit.sv =====
// Testbench top for radial_scaled_deadzone_unit: drives samples and dead-zone
// settings, stalls both sides at random; rsdz_scoreboard does the checking.
// Depends on rsdz_pkg, the unit and rsdz_scoreboard.
`timescale 1ns / 100ps

module tb_radial_scaled_deadzone_unit;

  localparam int FS = 32767;
  localparam int DRAIN = 100;
  localparam int STALL_LIMIT = 3000;

  logic        clk, rst;
  logic        dz_radius_we;
  logic [14:0] dz_radius_wdata;
  logic        in_valid, in_ready;
  logic [14:0] up_in, left_in, down_in, right_in;
  logic        out_valid, out_ready;
  logic [14:0] up_out, left_out, down_out, right_out;
  logic        active;
  int          pending, fail_count;
  bit          quiet;
  int          sink_hold;
  int          idle_cycles;
  logic [14:0] dz_now;

  radial_scaled_deadzone_unit #(.FULL_SCALE(FS)) DUT (.*);

  rsdz_scoreboard #(.FULL_SCALE(FS)) u_scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall in short bursts, none in the quiet phase
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      sink_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one sample and hold it until it transfers
  task automatic send_sample(input logic [14:0] u, input logic [14:0] l,
                             input logic [14:0] d, input logic [14:0] r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    up_in    <= u;
    left_in  <= l;
    down_in  <= d;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let the pipeline empty, then write the dead-zone radius
  task automatic set_dz_radius(input logic [14:0] v);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    dz_radius_we    <= 1'b1;
    dz_radius_wdata <= v;
    @(posedge clk);
    dz_radius_we <= 1'b0;
    dz_now = v;
    @(posedge clk);
  endtask

  function automatic logic [14:0] near(input int c, input int spread);
    int v;
    v = c + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > FS) v = FS;
    return 15'(v);
  endfunction

  // Random sample of mixed shapes
  task automatic random_sample();
    int          kind;
    logic [14:0] a, b;
    kind = $urandom_range(0, 5);
    a = 15'($urandom);
    b = 15'($urandom);
    case (kind)
      0: send_sample(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
      1: begin
        // one axis near the dead-zone edge
        a = near(dz_now, 4);
        if ($urandom_range(0, 1)) send_sample(15'd0, 15'd0, 15'd0, a);
        else send_sample(a, 15'd0, 15'd0, 15'd0);
      end
      2: begin
        // diagonal near the dead-zone radius
        a = near(dz_now * 707 / 1000, 30);
        b = near(dz_now * 707 / 1000, 30);
        send_sample($urandom_range(0, 1) ? a : 15'd0, $urandom_range(0, 1) ? b : 15'd0,
                    $urandom_range(0, 1) ? 15'd0 : a, $urandom_range(0, 1) ? 15'd0 : b);
      end
      3: send_sample(15'd0, a, b, 15'd0);
      4: send_sample(near(FS, 200), near(FS, 200), 15'($urandom_range(0, 2000)), 15'($urandom));
      default: send_sample(a, 15'd0, 15'd0, b);
    endcase
  endtask

  initial begin
    logic [14:0] dz_list[5];
    rst = 1'b1;
    quiet = 1'b0;
    dz_radius_we = 1'b0;
    dz_radius_wdata = '0;
    in_valid = 1'b0;
    up_in = '0;
    left_in = '0;
    down_in = '0;
    right_in = '0;
    dz_now = 15'd2000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples at the reset dead zone
    send_sample(15'd0, 15'd0, 15'd0, 15'd0);
    send_sample(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_sample(15'd0, 15'd0, 15'd0, 15'd2000);
    send_sample(15'd0, 15'd0, 15'd0, 15'd1999);
    send_sample(15'd0, 15'h7FFF, 15'd0, 15'd0);
    send_sample(15'h7FFF, 15'd0, 15'd0, 15'd0);
    send_sample(15'd0, 15'd0, 15'h7FFF, 15'd0);
    send_sample(15'd0, 15'd0, 15'h7FFF, 15'h7FFF);
    send_sample(15'h7FFF, 15'h7FFF, 15'd0, 15'd0);
    send_sample(15'd12000, 15'd0, 15'd12000, 15'd30000);
    send_sample(15'h5555, 15'h2AAA, 15'h2AAA, 15'h5555);
    send_sample(15'h2AAA, 15'h5555, 15'h5555, 15'h2AAA);
    send_sample(15'd0, 15'd1415, 15'd1415, 15'd0);
    send_sample(15'd100, 15'd32767, 15'd32000, 15'd0);
    send_sample(15'd1, 15'd0, 15'd0, 15'd1);
    repeat (350) random_sample();

    // Further dead-zone settings, extremes first; the last phase runs quiet
    dz_list[0] = 15'd1;
    dz_list[1] = 15'd32766;
    dz_list[2] = 15'($urandom_range(1, 32766));
    dz_list[3] = 15'd16384;
    dz_list[4] = 15'($urandom_range(1, 4000));
    foreach (dz_list[i]) begin
      set_dz_radius(dz_list[i]);
      if (i == 4) quiet = 1'b1;
      send_sample(15'd0, 15'd0, 15'd0, dz_list[i]);
      send_sample(15'd0, 15'd0, 15'd0, dz_list[i] - 15'd1);
      send_sample(15'd0, dz_list[i], 15'd0, 15'd0);
      send_sample(15'h7FFF, 15'h7FFF, 15'd0, 15'd0);
      repeat (320) random_sample();
    end
    in_valid <= 1'b0;

    // Drain and give the verdict
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== radial_scaled_deadzone_unit.f =====
+incdir+rtl/core
rtl/core/rsdz_pkg.sv
rtl/core/radial_scaled_deadzone_unit.sv
verif/rsdz_scoreboard.sv
verif/tb_radial_scaled_deadzone_unit.sv
